// ----- rtl/core/vmst_pkg.sv -----
package vmst_pkg;

	localparam int VALUE_W = 32;
	localparam int COUNT_W = 7;

	// command codes
	localparam logic [1:0] CMD_INSERT = 2'd0;
	localparam logic [1:0] CMD_DELETE = 2'd1;
	localparam logic [1:0] CMD_SEARCH = 2'd2;

	// status codes
	localparam logic [2:0] ST_INSERTED  = 3'd0;
	localparam logic [2:0] ST_DELETED   = 3'd1;
	localparam logic [2:0] ST_FOUND     = 3'd2;
	localparam logic [2:0] ST_NOT_FOUND = 3'd3;
	localparam logic [2:0] ST_FULL      = 3'd4;

	typedef struct packed {
		logic [1:0]                cmd;
		logic signed [VALUE_W-1:0] value;
	} req_t;

	typedef struct packed {
		logic [2:0]         status;
		logic [COUNT_W-1:0] entry_count;
	} rsp_t;

	// request token walking down the cell chain
	typedef struct packed {
		logic                      valid;
		logic                      done;
		logic [1:0]                cmd;
		logic signed [VALUE_W-1:0] value;
	} tok_t;

endpackage

// ----- rtl/core/vmst_cell.sv -----
module vmst_cell (
	input  logic          clk,
	input  logic          arst_n,
	input  logic          advance,
	input  vmst_pkg::tok_t tok_in,
	output vmst_pkg::tok_t tok_out
);
	import vmst_pkg::*;

	logic                      ent_vld_q;
	logic signed [VALUE_W-1:0] ent_val_q;
	logic                      tok_vld_q;
	logic                      tok_done_q;
	logic [1:0]                tok_cmd_q;
	logic signed [VALUE_W-1:0] tok_val_q;
	logic                      match;
	logic                      hit;

	assign match = ent_vld_q && (ent_val_q == tok_in.value);

	// first free cell takes an insert, first matching cell takes a delete or search
	always_comb begin
		hit = 1'b0;
		if (tok_in.valid && !tok_in.done) begin
			if (tok_in.cmd == CMD_INSERT) begin
				hit = !ent_vld_q;
			end else if (tok_in.cmd == CMD_DELETE || tok_in.cmd == CMD_SEARCH) begin
				hit = match;
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			ent_vld_q <= 1'b0;
			tok_vld_q <= 1'b0;
		end else if (advance) begin
			tok_vld_q <= tok_in.valid;
			if (hit && tok_in.cmd == CMD_INSERT) begin
				ent_vld_q <= 1'b1;
			end else if (hit && tok_in.cmd == CMD_DELETE) begin
				ent_vld_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (advance) begin
			tok_done_q <= tok_in.done | hit;
			tok_cmd_q  <= tok_in.cmd;
			tok_val_q  <= tok_in.value;
			if (hit && tok_in.cmd == CMD_INSERT) begin
				ent_val_q <= tok_in.value;
			end
		end
	end

	assign tok_out.valid = tok_vld_q;
	assign tok_out.done  = tok_done_q;
	assign tok_out.cmd   = tok_cmd_q;
	assign tok_out.value = tok_val_q;

endmodule

// ----- rtl/core/vmst_out.sv -----
module vmst_out #(
	parameter int CAPACITY = 64
) (
	input  logic           clk,
	input  logic           arst_n,
	input  vmst_pkg::tok_t tok_in,
	input  logic           rsp_stall,
	output logic           advance,
	output logic           rsp_valid,
	output vmst_pkg::rsp_t rsp
);
	import vmst_pkg::*;

	localparam int CNT_W = $clog2(CAPACITY + 1);

	logic [CNT_W-1:0] cnt_q;
	logic [CNT_W-1:0] cnt_nxt;
	logic [2:0]       status;
	logic             rsp_valid_q;
	rsp_t             rsp_q;

	assign advance = !rsp_valid_q || !rsp_stall;

	always_comb begin
		cnt_nxt = cnt_q;
		status  = ST_NOT_FOUND;
		case (tok_in.cmd)
			CMD_INSERT: begin
				status = tok_in.done ? ST_INSERTED : ST_FULL;
				if (tok_in.done) begin
					cnt_nxt = cnt_q + CNT_W'(1);
				end
			end
			CMD_DELETE: begin
				status = tok_in.done ? ST_DELETED : ST_NOT_FOUND;
				if (tok_in.done) begin
					cnt_nxt = cnt_q - CNT_W'(1);
				end
			end
			CMD_SEARCH: begin
				status = tok_in.done ? ST_FOUND : ST_NOT_FOUND;
			end
			default: begin
				status = ST_NOT_FOUND;
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			rsp_valid_q <= 1'b0;
			cnt_q       <= '0;
		end else if (advance) begin
			rsp_valid_q <= tok_in.valid;
			if (tok_in.valid) begin
				cnt_q <= cnt_nxt;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (advance && tok_in.valid) begin
			rsp_q.status      <= status;
			rsp_q.entry_count <= COUNT_W'(cnt_nxt);
		end
	end

	assign rsp_valid = rsp_valid_q;
	assign rsp       = rsp_q;

endmodule

// ----- rtl/core/value_multiset_table_core.sv -----
// bounded multiset of signed 32-bit values, duplicates allowed
// request channel: req_valid / req_stall / req (cmd, value)
//   cmd insert stores the value in the lowest free entry or answers full,
//   delete clears the lowest matching entry or answers not found,
//   search answers found or not found; an unused code answers not found
// response channel: rsp_valid / rsp_stall / rsp (status, entry_count)
//   entry_count is the number of entries held after the request
// the table is a chain of CAPACITY cells, one entry each; a request walks
//   one cell per unfrozen cycle; the first cell that can serve it claims it
// a request passes CAPACITY cell registers, then the response register
// throughput: one request per unfrozen cycle; a later request always trails
//   the earlier one down the chain, so it sees the table that one left behind
// reset clears all valid marks, the entry count and every in-flight request
// while rsp_stall holds a waiting response, the whole chain freezes and
//   req_stall is raised; the held response does not change
module value_multiset_table_core #(
	parameter int CAPACITY = 64
) (
	input  logic           clk,
	input  logic           arst_n,
	input  logic           req_valid,
	output logic           req_stall,
	input  vmst_pkg::req_t req,
	output logic           rsp_valid,
	input  logic           rsp_stall,
	output vmst_pkg::rsp_t rsp
);
	import vmst_pkg::*;

	// token entering cell i is tok_chain[i]; the last cell feeds the output stage
	tok_t tok_chain [CAPACITY+1];
	logic advance;

	// new request enters the first cell; nothing has claimed it yet
	assign tok_chain[0].valid = req_valid;
	assign tok_chain[0].done  = 1'b0;
	assign tok_chain[0].cmd   = req.cmd;
	assign tok_chain[0].value = req.value;

	// chain only moves when the response register can take what falls out
	assign req_stall = !advance;

	for (genvar i = 0; i < CAPACITY; i++) begin : g_cell
		vmst_cell u_cell (
			.clk     (clk),
			.arst_n  (arst_n),
			.advance (advance),
			.tok_in  (tok_chain[i]),
			.tok_out (tok_chain[i+1])
		);
	end

	// status decode, running entry count and response register
	vmst_out #(
		.CAPACITY (CAPACITY)
	) u_out (
		.clk       (clk),
		.arst_n    (arst_n),
		.tok_in    (tok_chain[CAPACITY]),
		.rsp_stall (rsp_stall),
		.advance   (advance),
		.rsp_valid (rsp_valid),
		.rsp       (rsp)
	);

endmodule

// ----- verif/tb_value_multiset_table_core.sv -----
module tb_value_multiset_table_core;
	timeunit 1ns;
	timeprecision 1ps;

	import vmst_pkg::*;

	localparam int CAPACITY = 64;

	// the core answers this code like a search that never matches
	localparam logic [1:0] CMD_UNUSED = 2'd3;

	logic clk = 1'b0;
	logic arst_n = 1'b0;
	logic req_valid = 1'b0;
	logic req_stall;
	req_t req = '0;
	logic rsp_valid;
	logic rsp_stall = 1'b0;
	rsp_t rsp;

	value_multiset_table_core #(
		.CAPACITY(CAPACITY)
	) DUT (
		.clk(clk),
		.arst_n(arst_n),
		.req_valid(req_valid),
		.req_stall(req_stall),
		.req(req),
		.rsp_valid(rsp_valid),
		.rsp_stall(rsp_stall),
		.rsp(rsp)
	);

	// 2 ns period
	always begin
		#1 clk = 1'b1;
		#1 clk = 1'b0;
	end

	// requests waiting to be driven, responses predicted but not yet seen
	req_t requests_todo[$];
	rsp_t answers_due[$];

	// mirror of the table contents; only valid slots are ever compared
	logic signed [VALUE_W-1:0] slot_val[CAPACITY];
	logic                      slot_used[CAPACITY] = '{default: 1'b0};
	int                        held_total = 0;

	// handshakes seen at the last rising edge
	logic req_taken = 1'b0;
	logic rsp_taken = 1'b0;

	// when set, neither side idles or stalls
	logic steady = 1'b0;

	int mismatches = 0;
	int requests_sent = 0;
	int responses_seen = 0;
	int peak_held = 0;
	int status_seen[8] = '{default: 0};

	// apply one request to the mirror and return the response it must produce
	function automatic rsp_t mset_apply(req_t r);
		rsp_t answer;
		int   match_slot;
		int   free_slot;
		match_slot = -1;
		free_slot  = -1;
		// scan downward so the lowest index wins
		for (int i = CAPACITY - 1; i >= 0; i--) begin
			if (slot_used[i] && slot_val[i] == r.value)
				match_slot = i;
			if (!slot_used[i])
				free_slot = i;
		end
		answer.status = ST_NOT_FOUND;
		case (r.cmd)
		CMD_INSERT: begin
			if (free_slot >= 0) begin
				slot_val[free_slot]  = r.value;
				slot_used[free_slot] = 1'b1;
				held_total++;
				answer.status = ST_INSERTED;
			end else begin
				answer.status = ST_FULL;
			end
		end
		CMD_DELETE: begin
			if (match_slot >= 0) begin
				slot_used[match_slot] = 1'b0;
				held_total--;
				answer.status = ST_DELETED;
			end
		end
		CMD_SEARCH: begin
			if (match_slot >= 0)
				answer.status = ST_FOUND;
		end
		default: begin
			// unused code: nothing changes
		end
		endcase
		answer.entry_count = COUNT_W'(held_total);
		return answer;
	endfunction

	task automatic note_mismatch(string what);
		mismatches++;
		if (mismatches <= 10)
			$display("[%0t] mismatch: %s", $realtime, what);
	endtask

	// sampling and checking on the rising edge
	always @(posedge clk) begin
		if (arst_n) begin
			req_taken <= req_valid && !req_stall;
			rsp_taken <= rsp_valid && !rsp_stall;
			if (rsp_valid && !rsp_stall) begin
				if (answers_due.size() == 0) begin
					note_mismatch($sformatf("response status %0d count %0d with none expected",
						rsp.status, rsp.entry_count));
				end else begin
					rsp_t want;
					want = answers_due.pop_front();
					if (rsp.status !== want.status)
						note_mismatch($sformatf("response %0d status: expected %0d, got %0d",
							responses_seen, want.status, rsp.status));
					if (rsp.entry_count !== want.entry_count)
						note_mismatch($sformatf("response %0d count: expected %0d, got %0d",
							responses_seen, want.entry_count, rsp.entry_count));
				end
				if (!$isunknown(rsp.status))
					status_seen[rsp.status]++;
				responses_seen++;
			end
			// the expectation is formed when the request is taken, in order
			if (req_valid && !req_stall) begin
				answers_due.push_back(mset_apply(req));
				requests_sent++;
				if (held_total > peak_held)
					peak_held = held_total;
			end
		end
	end

	// request driver: changes only on the falling edge, holds while stalled
	int send_gap = 0;
	always @(negedge clk) begin
		if (arst_n) begin
			if (!req_valid || req_taken) begin
				if (send_gap > 0) begin
					req_valid <= 1'b0;
					send_gap--;
				end else if (requests_todo.size() > 0) begin
					req       <= requests_todo.pop_front();
					req_valid <= 1'b1;
					// idle cycles after this request is taken
					send_gap = steady ? 0 : $urandom_range(0, 5);
				end else begin
					req_valid <= 1'b0;
				end
			end
		end
	end

	// response stall: a fresh stall window is drawn for every response taken
	int stall_left = 0;
	always @(negedge clk) begin
		if (arst_n) begin
			if (rsp_taken)
				stall_left = steady ? 0 : $urandom_range(0, 5);
			if (stall_left > 0) begin
				rsp_stall <= 1'b1;
				stall_left--;
			end else begin
				rsp_stall <= 1'b0;
			end
		end
	end

	task automatic queue_request(logic [1:0] c, logic [VALUE_W-1:0] v);
		req_t r;
		r.cmd   = c;
		r.value = v;
		requests_todo.push_back(r);
	endtask

	// a small pool so deletes and searches hit, plus extremes and noise
	function automatic logic [VALUE_W-1:0] pick_value();
		case ($urandom_range(0, 9))
		0: return 32'h8000_0000;
		1: return 32'h7FFF_FFFF;
		2: return 32'hFFFF_FFFF;
		3, 4, 5, 6: return VALUE_W'(int'($urandom_range(0, 11)) - 6);
		default: return $urandom();
		endcase
	endfunction

	// sender pauses until every predicted response has arrived
	task automatic wait_quiet();
		do
			@(negedge clk);
		while (requests_todo.size() != 0 || req_valid || answers_due.size() != 0);
		@(posedge clk);
	endtask

	// inserts with searches mixed in until the table is full, then six that must bounce
	task automatic queue_fill();
		int n;
		n = CAPACITY - held_total + 6;
		for (int i = 0; i < n; i++) begin
			if ($urandom_range(0, 9) == 0)
				queue_request(CMD_SEARCH, pick_value());
			queue_request(CMD_INSERT, pick_value());
		end
	endtask

	task automatic queue_mixed(int n);
		int pick;
		for (int i = 0; i < n; i++) begin
			pick = $urandom_range(0, 99);
			if (pick < 35)
				queue_request(CMD_INSERT, pick_value());
			else if (pick < 65)
				queue_request(CMD_DELETE, pick_value());
			else if (pick < 95)
				queue_request(CMD_SEARCH, pick_value());
			else
				queue_request(CMD_UNUSED, pick_value());
		end
	endtask

	// delete every held value in random order, with searches and misses mixed in
	task automatic queue_drain();
		logic [VALUE_W-1:0] held_vals[$];
		int                 k;
		for (int i = 0; i < CAPACITY; i++)
			if (slot_used[i])
				held_vals.push_back(slot_val[i]);
		while (held_vals.size() > 0) begin
			k = $urandom_range(0, held_vals.size() - 1);
			if ($urandom_range(0, 7) == 0)
				queue_request(CMD_SEARCH, held_vals[k]);
			if ($urandom_range(0, 11) == 0)
				queue_request(CMD_DELETE, $urandom());
			queue_request(CMD_DELETE, held_vals[k]);
			held_vals.delete(k);
		end
		// empty table: nothing may match any more
		queue_request(CMD_DELETE, 32'h0);
		queue_request(CMD_SEARCH, 32'hFFFF_FFFF);
		queue_request(CMD_UNUSED, 32'h8000_0000);
	endtask

	initial begin
		repeat (4) @(posedge clk);
		@(negedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// directed: empty table, extremes, duplicates, unused code, back to empty
		queue_request(CMD_SEARCH, 32'h0);
		queue_request(CMD_DELETE, 32'h8000_0000);
		queue_request(CMD_UNUSED, 32'h0);
		queue_request(CMD_INSERT, 32'h8000_0000);
		queue_request(CMD_INSERT, 32'h7FFF_FFFF);
		queue_request(CMD_INSERT, 32'h0);
		queue_request(CMD_INSERT, 32'hFFFF_FFFF);
		queue_request(CMD_INSERT, 32'h7FFF_FFFF);
		queue_request(CMD_SEARCH, 32'h8000_0000);
		queue_request(CMD_SEARCH, 32'h1);
		queue_request(CMD_SEARCH, 32'h7FFF_FFFE);
		// duplicate: one delete leaves the other copy findable
		queue_request(CMD_DELETE, 32'h7FFF_FFFF);
		queue_request(CMD_SEARCH, 32'h7FFF_FFFF);
		queue_request(CMD_DELETE, 32'h7FFF_FFFF);
		queue_request(CMD_SEARCH, 32'h7FFF_FFFF);
		queue_request(CMD_DELETE, 32'h7FFF_FFFF);
		// unused code on a held value must not touch it
		queue_request(CMD_UNUSED, 32'hFFFF_FFFF);
		queue_request(CMD_DELETE, 32'hFFFF_FFFF);
		queue_request(CMD_DELETE, 32'h0);
		queue_request(CMD_DELETE, 32'h8000_0000);
		queue_request(CMD_SEARCH, 32'h8000_0000);
		wait_quiet();

		// random rounds: fill past full, churn, drain; middle fill and churn never idle
		for (int round = 0; round < 3; round++) begin
			steady = (round == 1);
			queue_fill();
			wait_quiet();
			queue_mixed(100);
			wait_quiet();
			steady = 1'b0;
			queue_drain();
			wait_quiet();
		end

		// let any stray response show up
		repeat (CAPACITY + 20) @(posedge clk);

		$display("covered %0d requests, peak of %0d held entries", requests_sent, peak_held);
		$display("responses: %0d inserted, %0d deleted, %0d found, %0d not found, %0d full",
			status_seen[ST_INSERTED], status_seen[ST_DELETED], status_seen[ST_FOUND],
			status_seen[ST_NOT_FOUND], status_seen[ST_FULL]);
		if (mismatches == 0 && answers_due.size() == 0) begin
			$display("tb_value_multiset_table_core passed");
		end else begin
			$display("%0d mismatches in total, %0d responses never seen", mismatches,
				answers_due.size());
			$display("tb_value_multiset_table_core failed");
		end
		$finish;
	end

	// run limit, far beyond the slowest correct run
	initial begin
		#400000;
		$display("timeout with %0d responses outstanding", answers_due.size());
		$display("tb_value_multiset_table_core failed");
		$finish;
	end

endmodule

// ----- files.f -----
rtl/core/vmst_pkg.sv
rtl/core/vmst_cell.sv
rtl/core/vmst_out.sv
rtl/core/value_multiset_table_core.sv
verif/tb_value_multiset_table_core.sv
